// ===== sv/crc16bel_pkg.sv =====
// Shared types, constants and CRC helper functions for the CRC-16 burst error locator.
package crc16bel_pkg;

  // CRC-CCITT generator polynomial, MSB first.
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Largest supported packet in bytes; default of the top-level parameter.
  localparam int MAX_PACKET_BYTES_DEF = 32;

  // Field widths.
  localparam int LEN_W = 6;
  localparam int HDR_W = 5;
  localparam int POS_W = 5;
  localparam int PAT_W = 3;
  localparam int SHF_W = 3;
  localparam int KEY_W = PAT_W + POS_W + SHF_W;

  // Register map, indexed by the word address bit.
  localparam logic REG_PACKET_LENGTH = 1'b0;
  localparam logic REG_HEADER_BYTES  = 1'b1;

  // Register reset values.
  localparam logic [LEN_W-1:0] PACKET_LENGTH_RST = 6'd29;
  localparam logic [HDR_W-1:0] HEADER_BYTES_RST  = 5'd3;

  // Search sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_PAIR,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Burst pattern words, all starting with a one in the top bit.
  function automatic logic [15:0] burst_word(input logic [PAT_W-1:0] pat);
    logic [15:0] w;
    unique case (pat)
      3'd0: w = 16'h8000;
      3'd1: w = 16'hC000;
      3'd2: w = 16'hA000;
      3'd3: w = 16'h9000;
      3'd4: w = 16'hE000;
      3'd5: w = 16'hD000;
      3'd6: w = 16'hB000;
      default: w = 16'hF000;
    endcase
    return w;
  endfunction

  // Number of flipped bits in each burst pattern.
  function automatic logic [2:0] burst_ones(input logic [PAT_W-1:0] pat);
    logic [2:0] n;
    unique case (pat)
      3'd0: n = 3'd1;
      3'd1, 3'd2, 3'd3: n = 3'd2;
      3'd4, 3'd5, 3'd6: n = 3'd3;
      default: n = 3'd4;
    endcase
    return n;
  endfunction

  // One byte through the CRC register, eight bit steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/crc16_burst_error_locator.sv =====
// CRC-16 burst error locator: searches all bursts for one whose CRC equals the syndrome.
//
//   Channel  Direction  Signals                                  Content
//   s_*      in         s_tvalid s_tready s_tdata[15:0]          syndrome
//   m_*      out        m_tvalid m_tready m_tdata[23:0]          correction result
//   apb      in/out     psel penable pwrite paddr pwdata prdata  packet_length, header_bytes
//
// The search time for one syndrome grows with the effective length L. It is set by the
// single byte-wide CRC unit, which steps one byte position a cycle for each of the 64 burst
// candidates.
// Reset (rst, synchronous) clears the sequencer and loads the register reset values.
// s_tready is low while a search runs; a finished result waits in the output register,
// and a new syndrome is taken while it waits.
module crc16_burst_error_locator
  import crc16bel_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] syndrome
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [2:0] bits_corrected, [7:3] byte_index,
                                 // [15:8] first_mask, [23:16] second_mask
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [LEN_W-1:0] packet_length;
  logic [HDR_W-1:0] header_bytes;

  // Search state.
  state_t           state, state_next;
  logic [15:0]      syn;
  logic [LEN_W-1:0] len;
  logic [PAT_W-1:0] pat;
  logic [SHF_W-1:0] shift;
  logic [POS_W-1:0] pos;
  logic [15:0]      crc;
  logic             found;
  logic [KEY_W-1:0] best;

  // Combinational signals.
  logic [LEN_W-1:0] len_in;
  logic [15:0]      word;
  logic [15:0]      unit_crc;
  logic [7:0]       unit_data;
  logic [15:0]      unit_out;
  logic             cand_hit;
  logic [POS_W-1:0] cand_pos;
  logic [KEY_W-1:0] cand_key;
  logic             take;
  logic             last_cand;
  logic             in_xfer;
  logic             out_load;
  logic             cfg_wr;

  // Result forming.
  logic [PAT_W-1:0] best_pat;
  logic [POS_W-1:0] best_pos;
  logic [SHF_W-1:0] best_shift;
  logic [15:0]      best_word;
  logic             correctable;

  // Configuration access: always ready, word addresses only.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_length <= PACKET_LENGTH_RST;
      header_bytes  <= HEADER_BYTES_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_PACKET_LENGTH: packet_length <= pwdata[LEN_W-1:0];
        REG_HEADER_BYTES:  header_bytes  <= pwdata[HDR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PACKET_LENGTH: prdata = {{(32-LEN_W){1'b0}}, packet_length};
      REG_HEADER_BYTES:  prdata = {{(32-HDR_W){1'b0}}, header_bytes};
    endcase
  end

  // Handshakes.
  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // Effective length, clamped to the largest supported packet.
  assign len_in = (packet_length > LEN_W'(MAX_PACKET_BYTES)) ?
                  LEN_W'(MAX_PACKET_BYTES) : packet_length;

  // Current candidate word and the last-candidate flag.
  assign word      = burst_word(pat) >> shift;
  assign last_cand = (pat == PAT_W'(7)) && (shift == SHF_W'(7));

  // Shared CRC byte unit.
  assign unit_out = crc_byte(unit_crc, unit_data);

  // Unit operand selection and candidate match per state.
  always_comb begin
    unit_crc  = 16'h0000;
    unit_data = 8'h00;
    cand_hit  = 1'b0;
    cand_pos  = pos;
    unique case (state)
      ST_HEAD: begin
        unit_data = word[15:8];
        cand_hit  = (word[7:0] == 8'h00) && (unit_out == syn);
        cand_pos  = POS_W'(len - LEN_W'(1));
      end
      ST_PAIR: begin
        unit_crc  = crc;
        unit_data = word[7:0];
      end
      ST_SCAN: begin
        unit_crc = crc;
        cand_hit = (crc == syn);
      end
      default: begin
        unit_crc = 16'h0000;
      end
    endcase
  end

  // The lowest key in (pattern, position, shift) order wins.
  assign cand_key = {pat, cand_pos, shift};
  assign take     = cand_hit && (!found || (cand_key < best));

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = (len_in == '0) ? ST_DONE : ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (len < LEN_W'(2)) begin
          state_next = last_cand ? ST_DONE : ST_HEAD;
        end else begin
          state_next = ST_PAIR;
        end
      end
      ST_PAIR: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (pos == '0) begin
          state_next = last_cand ? ST_DONE : ST_HEAD;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            syn   <= s_tdata;
            len   <= len_in;
            pat   <= '0;
            shift <= '0;
            found <= 1'b0;
          end
        end
        ST_HEAD: begin
          crc <= unit_out;
          if (take) begin
            found <= 1'b1;
            best  <= cand_key;
          end
          if (len < LEN_W'(2)) begin
            {pat, shift} <= {pat, shift} + (PAT_W + SHF_W)'(1);
          end
        end
        ST_PAIR: begin
          crc <= unit_out;
          pos <= POS_W'(len - LEN_W'(2));
        end
        ST_SCAN: begin
          crc <= unit_out;
          if (take) begin
            found <= 1'b1;
            best  <= cand_key;
          end
          if (pos == '0) begin
            {pat, shift} <= {pat, shift} + (PAT_W + SHF_W)'(1);
          end else begin
            pos <= pos - POS_W'(1);
          end
        end
        default: begin
          found <= found;
        end
      endcase
    end
  end

  // Result fields from the winning candidate.
  assign best_pat    = best[KEY_W-1 -: PAT_W];
  assign best_pos    = best[SHF_W +: POS_W];
  assign best_shift  = best[SHF_W-1:0];
  assign best_word   = burst_word(best_pat) >> best_shift;
  assign correctable = found && ({1'b0, best_pos} >= {{(POS_W+1-HDR_W){1'b0}}, header_bytes});

  // Output register: a result waits here until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (correctable) begin
        m_tdata <= {best_word[7:0], best_word[15:8],
                    POS_W'(best_pos - POS_W'(header_bytes)), burst_ones(best_pat)};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  // The scan position always lies inside the packet.
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ({1'b0, pos} < len))
    else $error("scan position beyond packet length");

  // A finished search always lands in the output register.
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("result not loaded after search");

  // A result that is not correctable carries all-zero fields.
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[2:0] == 3'd0)) |-> (m_tdata[23:3] == '0))
    else $error("uncorrectable result with nonzero fields");

  // A new syndrome is taken only with the sequencer idle and the search restarts at pattern 0.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> ((pat == '0) && (shift == '0) && !found))
    else $error("search did not restart");

endmodule
